>>> rtl/core/windowed_per_type_admission_limiter_top_macros.svh
// Assertion helpers for the admission limiter.
`ifndef WINDOWED_PER_TYPE_ADMISSION_LIMITER_TOP_MACROS_SVH
`define WINDOWED_PER_TYPE_ADMISSION_LIMITER_TOP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define WPAL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define WPAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/wpal_pkg.sv
package wpal_pkg;

   localparam int ITEM_W     = 10;  // item_type field
   localparam int CFG_W      = 9;   // window_len, max_per_type
   localparam int CNT_W      = 9;   // per-type kept count
   localparam int TOTAL_W    = 32;  // discard total
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [0:0] {
      REG_WINDOW_LEN   = 1'b0,
      REG_MAX_PER_TYPE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] discard_total;
      logic               discarded;
   } result_type;

endpackage

>>> rtl/core/windowed_per_type_admission_limiter_top.sv
// Channel | Dir | Handshake            | Payload
// req     | in  | req_tvalid/tready    | tdata[9:0] item_type
// rsp     | out | rsp_tvalid/tready    | tdata[0] discarded, tdata[32:1] discard_total
// csr     | in  | psel/penable/pwrite  | paddr[2] register, pwdata[8:0] value
//
// No new item is accepted while the previous one sits in s1; the count table's single write port takes the
// increment in one cycle and the leaving type's decrement in the next.
// The result is pushed from the s2 decision stage into a 2-entry output queue (head and skid).
// After reset the count table is swept to zero, one entry a cycle, through all NUM_TYPES entries;
// req_tready stays low meanwhile, CSR writes are taken as usual.
// A stalled rsp side only blocks req once the output queue, counting the item in s2, is full.
`include "windowed_per_type_admission_limiter_top_macros.svh"

module windowed_per_type_admission_limiter_top #(
   parameter int NUM_TYPES  = 1024,
   parameter int MAX_WINDOW = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [wpal_pkg::REQ_DATA_W-1:0]   req_tdata,   // [9:0] item_type, rest zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wpal_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [0] discarded, [32:1] discard_total
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wpal_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wpal_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wpal_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import wpal_pkg::*;

   localparam int KIND_W = $clog2(NUM_TYPES);
   localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int HIST_W = KIND_W + 1;           // {kept, kind}

   localparam logic [KIND_W-1:0] LAST_TYPE = KIND_W'(NUM_TYPES - 1);
   localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(MAX_WINDOW - 1);

   // ---------------- configuration registers ----------------
   logic [CFG_W-1:0] window_len_ff, max_per_type_ff;
   reg_index_type    csr_idx;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff   <= CFG_W'(1);
         max_per_type_ff <= CFG_W'(1);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_WINDOW_LEN:   window_len_ff   <= csr_pwdata[CFG_W-1:0];
            REG_MAX_PER_TYPE: max_per_type_ff <= csr_pwdata[CFG_W-1:0];
            default:          window_len_ff   <= window_len_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_WINDOW_LEN:   csr_prdata = CSR_DATA_W'(window_len_ff);
         REG_MAX_PER_TYPE: csr_prdata = CSR_DATA_W'(max_per_type_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- memories ----------------
   logic [CNT_W-1:0]  count_mem [NUM_TYPES];
   logic [HIST_W-1:0] hist_mem  [MAX_WINDOW];

   logic              cnt_we;
   logic [KIND_W-1:0] cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]  cnt_wdata, cnt_rdata_ff;
   logic              hist_we;
   logic [PTR_W-1:0]  hist_waddr, hist_raddr;
   logic [HIST_W-1:0] hist_wdata, hist_rdata_ff;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rdata_ff <= count_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rdata_ff <= hist_mem[hist_raddr];
   end

   // Bypass: the write landing on the same edge as a read is missed by that read.
   logic              cnt_byp_v_ff, hist_byp_v_ff;
   logic [KIND_W-1:0] cnt_byp_addr_ff, cnt_raddr_ff;
   logic [CNT_W-1:0]  cnt_byp_data_ff;
   logic [PTR_W-1:0]  hist_byp_addr_ff;
   logic [HIST_W-1:0] hist_byp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_byp_v_ff  <= 1'b0;
         hist_byp_v_ff <= 1'b0;
      end else begin
         cnt_byp_v_ff  <= cnt_we;
         hist_byp_v_ff <= hist_we;
      end
      cnt_byp_addr_ff  <= cnt_waddr;
      cnt_byp_data_ff  <= cnt_wdata;
      cnt_raddr_ff     <= cnt_raddr;
      hist_byp_addr_ff <= hist_waddr;
      hist_byp_data_ff <= hist_wdata;
   end

   // ---------------- clearing pass ----------------
   logic              clear_ff;
   logic [KIND_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clr_addr_ff <= clr_addr_ff + KIND_W'(1);
         if (clr_addr_ff == LAST_TYPE) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // ---------------- accept stage ----------------
   logic              req_acc;
   logic [ITEM_W-1:0] type_rem;
   logic [KIND_W-1:0] kind_in;
   logic [WIN_W-1:0]  win_eff, win_back;
   logic [WIN_W:0]    old_wide;
   logic [PTR_W-1:0]  old_in;
   logic [WIN_W-1:0]  seen_ff, seen_in;
   logic [PTR_W-1:0]  ring_ptr_ff, ring_ptr_in;

   assign req_acc = req_tvalid & req_tready;

   // type modulo NUM_TYPES by restoring subtraction against constant multiples
   always_comb begin
      type_rem = req_tdata[ITEM_W-1:0];
      for (int k = ITEM_W - 1; k >= 0; k--) begin
         if (32'(type_rem) >= (32'(NUM_TYPES) << k)) begin
            type_rem = type_rem - ITEM_W'(32'(NUM_TYPES) << k);
         end
      end
      kind_in = KIND_W'(type_rem);
   end

   always_comb begin
      if (window_len_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (32'(window_len_ff) > MAX_WINDOW) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = WIN_W'(window_len_ff);
      end
      win_back = win_eff - WIN_W'(1);
      // leaving slot = ring_ptr - (w-1), wrapped into the ring
      old_wide = (WIN_W+1)'(ring_ptr_ff) + (WIN_W+1)'(MAX_WINDOW) - (WIN_W+1)'(win_back);
      if (old_wide >= (WIN_W+1)'(MAX_WINDOW)) begin
         old_wide = old_wide - (WIN_W+1)'(MAX_WINDOW);
      end
      old_in = old_wide[PTR_W-1:0];
      seen_in = (32'(seen_ff) < MAX_WINDOW) ? seen_ff + WIN_W'(1) : seen_ff;
      ring_ptr_in = (ring_ptr_ff == LAST_SLOT) ? '0 : ring_ptr_ff + PTR_W'(1);
   end

   // ---------------- pipeline registers ----------------
   logic              s1_valid_ff, s1_leave_ff, s1_w1_ff;
   logic [KIND_W-1:0] s1_kind_ff;
   logic [PTR_W-1:0]  s1_slot_ff, s1_old_ff;
   logic              s2_valid_ff, s2_leave_ff, s2_w1_ff;
   logic [KIND_W-1:0] s2_kind_ff;
   logic [PTR_W-1:0]  s2_slot_ff, s2_old_ff;
   logic              s3_valid_ff;
   logic [KIND_W-1:0] s3_kind_ff;
   logic [PTR_W-1:0]  s3_old_ff;

   // decision stage (s2): read data for the arriving type and leaving slot is here
   logic [CNT_W-1:0]  cnt_cur;
   logic [HIST_W-1:0] hist_cur, hist_leave;
   logic              drop, kept, inc_we, dec_start;
   logic [KIND_W-1:0] leave_kind;
   logic              dec_we;

   assign cnt_cur  = (cnt_byp_v_ff && cnt_byp_addr_ff == cnt_raddr_ff)
                     ? cnt_byp_data_ff : cnt_rdata_ff;
   assign hist_cur = (hist_byp_v_ff && hist_byp_addr_ff == s2_old_ff)
                     ? hist_byp_data_ff : hist_rdata_ff;

   assign drop       = cnt_cur >= max_per_type_ff;
   assign kept       = ~drop;
   assign inc_we     = s2_valid_ff & kept & (cnt_cur != COUNT_MAX);
   // window of one: the arrival leaves right after it enters
   assign hist_leave = s2_w1_ff ? {kept, s2_kind_ff} : hist_cur;
   assign leave_kind = hist_leave[KIND_W-1:0];
   assign dec_start  = s2_valid_ff & s2_leave_ff & hist_leave[KIND_W];
   // s3: count of the leaving type is here; never drops below zero
   assign dec_we     = s3_valid_ff & (cnt_cur != '0);

   assign cnt_raddr  = s1_valid_ff ? s1_kind_ff : leave_kind;
   assign hist_raddr = s1_old_ff;

   always_comb begin
      cnt_we    = clear_ff | inc_we | dec_we;
      cnt_waddr = s3_kind_ff;
      cnt_wdata = cnt_cur - CNT_W'(1);
      if (clear_ff) begin
         cnt_waddr = clr_addr_ff;
         cnt_wdata = '0;
      end else if (inc_we) begin
         cnt_waddr = s2_kind_ff;
         cnt_wdata = cnt_cur + CNT_W'(1);
      end
   end

   // new entry in the decision cycle, kept flag cleared when it leaves
   assign hist_we    = s2_valid_ff | s3_valid_ff;
   assign hist_waddr = s2_valid_ff ? s2_slot_ff : s3_old_ff;
   assign hist_wdata = s2_valid_ff ? {kept, s2_kind_ff} : {1'b0, s3_kind_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         seen_ff     <= '0;
         ring_ptr_ff <= '0;
      end else begin
         s1_valid_ff <= req_acc;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= dec_start;
         if (req_acc) begin
            seen_ff     <= seen_in;
            ring_ptr_ff <= ring_ptr_in;
         end
      end
      if (req_acc) begin
         s1_kind_ff  <= kind_in;
         s1_slot_ff  <= ring_ptr_ff;
         s1_old_ff   <= old_in;
         s1_leave_ff <= seen_in >= win_eff;
         s1_w1_ff    <= win_eff == WIN_W'(1);
      end
      s2_kind_ff  <= s1_kind_ff;
      s2_slot_ff  <= s1_slot_ff;
      s2_old_ff   <= s1_old_ff;
      s2_leave_ff <= s1_leave_ff;
      s2_w1_ff    <= s1_w1_ff;
      s3_kind_ff  <= leave_kind;
      s3_old_ff   <= s2_old_ff;
   end

   // ---------------- discard total ----------------
   logic [TOTAL_W-1:0] total_ff, total_in;

   assign total_in = (s2_valid_ff && drop && total_ff != TOTAL_MAX)
                     ? total_ff + TOTAL_W'(1) : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // ---------------- output queue (head + skid) ----------------
   result_type res, head_ff, head_in, skid_ff, skid_in;
   logic       head_v_ff, head_v_in, skid_v_ff, skid_v_in;
   logic       push, pop;
   logic [1:0] occupancy;

   assign res.discarded     = drop;
   assign res.discard_total = total_in;
   assign push = s2_valid_ff;
   assign pop  = rsp_tvalid & rsp_tready;

   always_comb begin
      head_v_in = head_v_ff;
      head_in   = head_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (pop) begin
         if (skid_v_ff) begin
            head_in   = skid_ff;
            head_v_in = 1'b1;
            skid_v_in = push;
            skid_in   = res;
         end else begin
            head_v_in = push;
            head_in   = res;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (head_v_ff) begin
            skid_v_in = 1'b1;
            skid_in   = res;
         end else begin
            head_v_in = 1'b1;
            head_in   = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // queue slots reserved by the item now deciding
   assign occupancy  = {1'b0, head_v_ff} + {1'b0, skid_v_ff} + {1'b0, s2_valid_ff};
   assign req_tready = ~clear_ff & ~s1_valid_ff & (occupancy < 2'd2);

   assign rsp_tvalid = head_v_ff;
   assign rsp_tdata  = RSP_DATA_W'({head_ff.discard_total, head_ff.discarded});

   // ---------------- assertions ----------------
   `WPAL_ASSERT_NEXT(a_issue_gap, clock, reset, req_acc, !req_tready, "item accepted back to back")
   `WPAL_ASSERT_ALWAYS(a_cnt_port, clock, reset, !(inc_we && dec_we), "count write collision")
   `WPAL_ASSERT_ALWAYS(a_q_room, clock, reset, !(push && head_v_ff && skid_v_ff && !pop), "queue overflow")
   `WPAL_ASSERT_ALWAYS(a_stage_excl, clock, reset, !(s1_valid_ff && s2_valid_ff), "read port contention")
   `WPAL_ASSERT_NEXT(a_result_out, clock, reset, s2_valid_ff, rsp_tvalid, "result not queued")

endmodule
